// ===== src/itf_pkg.sv =====
// ----------------------------------------------------------------------------
// itf_pkg - integer to text formatter package
// Conversion codes, sequencer states and ASCII constants shared by the
// formatter, its conversion unit and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package itf_pkg;

   // Conversion kinds as they arrive on the request channel
   typedef enum logic [2:0] {
      FUNC_D  = 3'd0,
      FUNC_U  = 3'd1,
      FUNC_O  = 3'd2,
      FUNC_XL = 3'd3,
      FUNC_XU = 3'd4
   } itf_func_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_SIZE,
      ST_EMIT
   } itf_state_type;

   // Handshake between the sequencer and the binary to BCD unit
   typedef struct packed {
      logic start;
      logic done;
   } itf_dab_ctl_type;

   // ASCII codes
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [6:0] CHAR_PLUS  = 7'h2B;
   localparam logic [6:0] CHAR_SPACE = 7'h20;
   localparam logic [6:0] CHAR_LX    = 7'h78;
   localparam logic [6:0] CHAR_UX    = 7'h58;
   localparam logic [6:0] CHAR_LA    = 7'h61;
   localparam logic [6:0] CHAR_UA    = 7'h41;

   // One digit (0..15) to its ASCII character
   function automatic logic [6:0] itf_digit_char(input logic [3:0] digit,
                                                 input logic upper);
      logic [6:0] res;
      if (digit < 4'd10) begin
         res = CHAR_ZERO + 7'(digit);
      end else begin
         res = (upper ? CHAR_UA : CHAR_LA) + 7'(digit - 4'd10);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== src/integer_to_text_formatter_unit.sv =====
// Flow: d and u go through binary to BCD conversion after the accept, then a
// scan of up to NDEC digits, a sizing step and one char per cycle while not stalled.
// o, x and X skip the conversion; their scan covers up to NOCT or NHEX digits.
// One transaction at a time; a request stalls until the sequencer is idle again.
// The shared BCD loop dominates the decimal case.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// integer_to_text_formatter_unit - printf style integer formatter
// Formats one integer per transaction and streams its characters out, one
// per result transaction, marking the final character.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_text_formatter_unit
   import itf_pkg::*;
#(
   parameter int VALUE_BITS = 64,
   parameter int MAX_FIELD  = 60
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [63:0] req_value,
   input  wire logic [5:0]  req_precision,
   input  wire logic        req_precision_given,
   input  wire logic [5:0]  req_min_width,
   input  wire logic        req_zero_pad,
   input  wire logic        req_left_align,
   input  wire logic        req_alt_form,
   input  wire logic        req_space_sign,
   input  wire logic        req_plus_sign,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [6:0]  rsp_out_char,
   output      logic        rsp_last_char
);

   localparam int NDEC = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int NOCT = (VALUE_BITS + 2) / 3;
   localparam int NHEX = (VALUE_BITS + 3) / 4;
   localparam int NDIG = NOCT;
   localparam int DIW  = $clog2(NDIG);
   localparam int NMAX = (NDIG > MAX_FIELD) ? NDIG : MAX_FIELD;
   localparam int LW   = $clog2(NMAX + 4);
   localparam logic [5:0] FIELD_SAT = 6'(MAX_FIELD);

   itf_state_type         state_ff, state_in;
   itf_func_type          func_ff, func_in, func_norm;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  zero_ff, zero_in;
   logic [5:0]            prec_ff, prec_in;
   logic                  pgiven_ff, pgiven_in;
   logic [5:0]            width_ff, width_in;
   logic                  zpad_ff, zpad_in;
   logic                  alt_ff, alt_in;
   logic                  space_ff, space_in;
   logic                  plus_ff, plus_in;
   logic [DIW-1:0]        idx_ff, idx_in;
   logic [LW-1:0]         nd_ff, nd_in;
   logic [LW-1:0]         b1_ff, b1_in;
   logic [LW-1:0]         b2_ff, b2_in;
   logic [LW-1:0]         b3_ff, b3_in;
   logic [LW-1:0]         n_ff, n_in;
   logic [LW-1:0]         pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [6:0]            rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   itf_dab_ctl_type       dab_req, dab_rsp;
   logic [4*NDEC-1:0]     bcd;

   logic [VALUE_BITS-1:0] acc_v, acc_mag;
   logic                  acc_neg;
   logic [5:0]            acc_prec, acc_width;
   logic [DIW-1:0]        acc_idx;
   logic                  accept, out_free;

   logic [4*NDIG-1:0]     dec_vec, hex_vec;
   logic [3*NDIG-1:0]     oct_vec;
   logic [DIW-1:0]        dig_idx, emit_idx;
   logic [3:0]            digit;

   logic                  altnz, aoz, nsign;
   logic [1:0]            npfx;
   logic [LW-1:0]         nd_eff, len, prec_l, wid_l, pad_len;
   logic [6:0]            char_sel, sign_char;

   // --- shared binary to BCD unit ---
   itf_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .NDEC       (NDEC)
   ) u_dabble (
      .clock   (clock),
      .reset   (reset),
      .value   (mag_in),
      .ctl_in  (dab_req),
      .ctl_out (dab_rsp),
      .bcd     (bcd)
   );

   // --- request decode: unused codes act as u ---
   always_comb begin
      case (req_func)
         FUNC_D:  func_norm = FUNC_D;
         FUNC_O:  func_norm = FUNC_O;
         FUNC_XL: func_norm = FUNC_XL;
         FUNC_XU: func_norm = FUNC_XU;
         default: func_norm = FUNC_U;
      endcase
   end

   always_comb begin
      acc_v     = req_value[VALUE_BITS-1:0];
      acc_neg   = (func_norm == FUNC_D) && acc_v[VALUE_BITS-1];
      acc_mag   = acc_neg ? (~acc_v + 1'b1) : acc_v;
      acc_prec  = (req_precision > FIELD_SAT) ? FIELD_SAT : req_precision;
      acc_width = (req_min_width > FIELD_SAT) ? FIELD_SAT : req_min_width;
      case (func_norm)
         FUNC_D, FUNC_U: acc_idx = DIW'(NDEC - 1);
         FUNC_O:         acc_idx = DIW'(NOCT - 1);
         default:        acc_idx = DIW'(NHEX - 1);
      endcase
   end

   // --- digit select, shared by the scan and the emit phases ---
   assign dec_vec  = (4*NDIG)'(bcd);
   assign oct_vec  = (3*NDIG)'(mag_ff);
   assign hex_vec  = (4*NDIG)'(mag_ff);
   assign emit_idx = DIW'(n_ff - pos_ff - 1'b1);
   assign dig_idx  = (state_ff == ST_SCAN) ? idx_ff : emit_idx;

   always_comb begin
      case (func_ff)
         FUNC_D, FUNC_U: digit = dec_vec[dig_idx*4 +: 4];
         FUNC_O:         digit = {1'b0, oct_vec[dig_idx*3 +: 3]};
         default:        digit = hex_vec[dig_idx*4 +: 4];
      endcase
   end

   // --- field sizing ---
   always_comb begin
      altnz  = alt_ff && !zero_ff;
      aoz    = alt_ff && zero_ff && (func_ff == FUNC_O);
      prec_l = LW'(prec_ff);
      wid_l  = LW'(width_ff);
      nsign  = neg_ff || ((func_ff != FUNC_U) && (plus_ff || space_ff));
      npfx   = 2'd0;
      if (altnz) begin
         if ((func_ff == FUNC_XL) || (func_ff == FUNC_XU)) begin
            npfx = 2'd2;
         end else if ((func_ff == FUNC_O) && (prec_ff == 6'd0)) begin
            npfx = 2'd1;
         end
      end
      nd_eff  = nd_ff;
      len     = (nd_ff > prec_l) ? nd_ff : prec_l;
      pad_len = wid_l - 1'b1 - LW'(altnz);
      if (zpad_ff && (wid_l > LW'(altnz) + 1'b1) && (pad_len > len)) begin
         len = pad_len;
      end
      // alternate octal zero is exactly one '0'
      if (aoz) begin
         nsign  = 1'b0;
         npfx   = 2'd0;
         nd_eff = LW'(1);
         len    = LW'(1);
      end
   end

   // --- character at the current position ---
   always_comb begin
      sign_char = neg_ff ? CHAR_MINUS : (plus_ff ? CHAR_PLUS : CHAR_SPACE);
      if (pos_ff < b1_ff) begin
         char_sel = sign_char;
      end else if (pos_ff < b2_ff) begin
         if (pos_ff == b1_ff) begin
            char_sel = CHAR_ZERO;
         end else begin
            char_sel = (func_ff == FUNC_XU) ? CHAR_UX : CHAR_LX;
         end
      end else if (pos_ff < b3_ff) begin
         char_sel = CHAR_ZERO;
      end else begin
         char_sel = itf_digit_char(digit, func_ff == FUNC_XU);
      end
   end

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // --- sequencer ---
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      prec_in      = prec_ff;
      pgiven_in    = pgiven_ff;
      width_in     = width_ff;
      zpad_in      = zpad_ff;
      alt_in       = alt_ff;
      space_in     = space_ff;
      plus_in      = plus_ff;
      idx_in       = idx_ff;
      nd_in        = nd_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      n_in         = n_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      dab_req      = '0;

      // result register drains independently of the sequencer
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in   = func_norm;
               mag_in    = acc_mag;
               neg_in    = acc_neg;
               zero_in   = (acc_v == '0);
               prec_in   = acc_prec;
               pgiven_in = req_precision_given;
               width_in  = acc_width;
               zpad_in   = req_zero_pad && !req_left_align;
               alt_in    = req_alt_form;
               space_in  = req_space_sign;
               plus_in   = req_plus_sign;
               idx_in    = acc_idx;
               if ((func_norm == FUNC_D) || (func_norm == FUNC_U)) begin
                  dab_req.start = 1'b1;
                  state_in      = ST_CONV;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_CONV: begin
            if (dab_rsp.done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // leading digit search, top down
            if ((digit != 4'd0) || (idx_ff == '0)) begin
               if (zero_ff && pgiven_ff && (prec_ff == 6'd0)) begin
                  nd_in = '0;
               end else begin
                  nd_in = LW'(idx_ff) + 1'b1;
               end
               state_in = ST_SIZE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_SIZE: begin
            b1_in  = LW'(nsign);
            b2_in  = LW'(nsign) + LW'(npfx);
            b3_in  = LW'(nsign) + LW'(npfx) + (len - nd_eff);
            n_in   = LW'(nsign) + LW'(npfx) + len;
            pos_in = '0;
            if ((LW'(nsign) + LW'(npfx) + len) == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = char_sel;
               rsp_last_in  = (pos_ff == n_ff - 1'b1);
               pos_in       = pos_ff + 1'b1;
               if (pos_ff == n_ff - 1'b1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // --- state register ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // --- transaction and result payload registers ---
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      prec_ff     <= prec_in;
      pgiven_ff   <= pgiven_in;
      width_ff    <= width_in;
      zpad_ff     <= zpad_in;
      alt_ff      <= alt_in;
      space_ff    <= space_in;
      plus_ff     <= plus_in;
      idx_ff      <= idx_in;
      nd_ff       <= nd_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b3_ff       <= b3_in;
      n_ff        <= n_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/itf_dabble.sv =====
// ----------------------------------------------------------------------------
// itf_dabble - iterative binary to BCD converter
// Shift-and-add-3 unit: one value bit per cycle until all VALUE_BITS bits are in.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_dabble
   import itf_pkg::*;
#(
   parameter int VALUE_BITS = 64,
   parameter int NDEC       = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [VALUE_BITS-1:0] value,
   input  wire itf_dab_ctl_type       ctl_in,
   output      itf_dab_ctl_type       ctl_out,
   output      logic [4*NDEC-1:0]     bcd
);

   localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam logic [CW-1:0] LAST_STEP = CW'(VALUE_BITS - 1);

   logic                  run_ff,   run_in;
   logic [CW-1:0]         cnt_ff,   cnt_in;
   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [4*NDEC-1:0]     bcd_ff,   bcd_in;
   logic [4*NDEC-1:0]     adj;

   // add 3 to every decade of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NDEC; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                     : bcd_ff[4*i +: 4];
      end
   end

   // step control
   always_comb begin
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      if (ctl_in.start) begin
         run_in   = 1'b1;
         cnt_in   = '0;
         shift_in = value;
         bcd_in   = '0;
      end else if (run_ff) begin
         bcd_in   = {adj[4*NDEC-2:0], shift_ff[VALUE_BITS-1]};
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
   end

   assign ctl_out.start = 1'b0;
   assign ctl_out.done  = run_ff && (cnt_ff == LAST_STEP);
   assign bcd           = bcd_ff;

endmodule

`default_nettype wire

// ===== src/itf_checker.sv =====
// ----------------------------------------------------------------------------
// itf_checker - port level checks for the integer to text formatter
// Watches both channels of the top level and flags sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_checker
   import itf_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [6:0] rsp_out_char,
   input wire logic       rsp_last_char
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char)
                                 && $stable(rsp_last_char))
      else $error("stalled result changed");

   // one transaction in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // when ready for input, any pending result is the final character
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      !req_stall && rsp_valid |-> rsp_last_char)
      else $error("ready with text still pending");

   // results start only while a transaction is being worked on
   a_rsp_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a transaction");

   // characters of one number follow back to back
   a_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_char |=> rsp_valid)
      else $error("gap inside a number");

endmodule

bind integer_to_text_formatter_unit itf_checker u_itf_checker (.*);

`default_nettype wire
